// ----- rtl/core/complex_fir_64_tap_core_assert.svh -----
// assertion macros for the complex fir core
`ifndef COMPLEX_FIR_64_TAP_CORE_ASSERT_SVH
`define COMPLEX_FIR_64_TAP_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CFIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfir assertion failed");
// next-cycle implication
`define CFIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfir assertion failed");
`else
`define CFIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CFIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/cfir_pkg.sv -----
`timescale 1ns / 1ps
package cfir_pkg;

  localparam int TAP_COUNT_DEF = 64;
  localparam int SMP_W         = 16;
  localparam int COEF_W        = 16;
  localparam int ACC_W         = 32;
  localparam int IDX_W         = 6;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic rd_en;
    logic clr;
    logic mul_en;
    logic acc_en;
    logic load;
  } seq_ctrl_t;

endpackage

// ----- rtl/core/cfir_ram.sv -----
`timescale 1ns / 1ps
module cfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/cfir_mac_lane.sv -----
`timescale 1ns / 1ps
module cfir_mac_lane (
  input  logic                                clk,
  input  cfir_pkg::seq_ctrl_t                 ctrl,
  input  logic signed [cfir_pkg::COEF_W-1:0]  coef,
  input  logic signed [cfir_pkg::SMP_W-1:0]   smp,
  output logic        [cfir_pkg::ACC_W-1:0]   acc
);
  import cfir_pkg::*;

  logic signed [ACC_W-1:0] prod_r;
  logic        [ACC_W-1:0] acc_r;

  // product register, then a wrapping accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= ACC_W'(coef * smp);
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

// ----- rtl/core/cfir_seq.sv -----
`timescale 1ns / 1ps
`include "complex_fir_64_tap_core_assert.svh"
module cfir_seq #(
  parameter int TAP_COUNT = cfir_pkg::TAP_COUNT_DEF,
  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                smp_acc,
  input  logic                out_free,
  output logic                in_stall,
  output logic [TAP_W-1:0]    wpos,
  output logic [TAP_W-1:0]    rd_addr,
  output logic [TAP_W-1:0]    coef_addr,
  output cfir_pkg::seq_ctrl_t ctrl
);
  import cfir_pkg::*;

  localparam logic [TAP_W-1:0] LAST_IDX = TAP_W'(TAP_COUNT - 1);

  seq_state_t       state_r, state_nxt;
  logic [TAP_W-1:0] cnt_r, cnt_nxt;
  logic [TAP_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [TAP_W-1:0] wpos_r, wpos_nxt;
  logic             p1_r, p2_r;
  logic             issue;
  logic             drained;

  assign issue   = (state_r == S_RUN);
  assign drained = !p1_r && !p2_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (smp_acc) state_nxt = S_RUN;
      S_RUN:   if (cnt_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: if (drained && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // tap counter walks coefficients upward, read address walks samples back in time
  always_comb begin
    cnt_nxt     = cnt_r;
    rd_addr_nxt = rd_addr_r;
    wpos_nxt    = wpos_r;
    if (smp_acc) begin
      cnt_nxt     = '0;
      rd_addr_nxt = wpos_r;
      wpos_nxt    = (wpos_r == LAST_IDX) ? '0 : wpos_r + TAP_W'(1);
    end else if (issue) begin
      cnt_nxt     = cnt_r + TAP_W'(1);
      rd_addr_nxt = (rd_addr_r == '0) ? LAST_IDX : rd_addr_r - TAP_W'(1);
    end
  end

  always_comb begin
    in_stall    = (state_r != S_IDLE);
    ctrl.rd_en  = issue;
    ctrl.clr    = smp_acc;
    ctrl.mul_en = p1_r;
    ctrl.acc_en = p2_r;
    ctrl.load   = (state_r == S_DRAIN) && drained && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rd_addr_r <= '0;
      wpos_r    <= '0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_addr_r <= rd_addr_nxt;
      wpos_r    <= wpos_nxt;
      p1_r      <= issue;
      p2_r      <= p1_r;
    end
  end

  assign wpos      = wpos_r;
  assign rd_addr   = rd_addr_r;
  assign coef_addr = cnt_r;

  `CFIR_ASSERT_NXT(a_start_run, clk, rst_n, smp_acc, (state_r == S_RUN) && (cnt_r == '0))
  `CFIR_ASSERT_NXT(a_run_ends, clk, rst_n, (state_r == S_RUN) && (cnt_r == LAST_IDX), state_r == S_DRAIN)
  `CFIR_ASSERT_NOW(a_load_drained, clk, rst_n, ctrl.load, !p1_r && !p2_r && out_free)
  `CFIR_ASSERT_NOW(a_idle_empty, clk, rst_n, state_r == S_IDLE, !p1_r && !p2_r)

endmodule

// ----- rtl/core/complex_fir_64_tap_core.sv -----
`timescale 1ns / 1ps
// a sample word holds the input stalled until its result is loaded into the output
// register; the run is set by one multiply-accumulate
// per rail per tap through the single read port of each tap memory
// a coefficient write word gives no result
// reset (synchronous, active low) zeroes the delay line and coefficients via valid bits
module complex_fir_64_tap_core #(
  parameter int TAP_COUNT = cfir_pkg::TAP_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic        [cfir_pkg::IDX_W-1:0]  in_tap_index,
  input  logic signed [cfir_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [cfir_pkg::SMP_W-1:0]  in_sample_i,
  input  logic signed [cfir_pkg::SMP_W-1:0]  in_sample_q,
  input  logic                               in_last_in_block,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cfir_pkg::SMP_W-1:0]  out_i,
  output logic signed [cfir_pkg::SMP_W-1:0]  out_q,
  output logic                               out_last_of_block
);
  import cfir_pkg::*;

  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  logic                  in_acc, smp_acc, coef_wr, out_free;
  logic [TAP_W-1:0]      wpos, rd_addr, coef_addr, coef_waddr;
  seq_ctrl_t             ctrl;
  logic [2*SMP_W-1:0]    dl_rdata;
  logic [COEF_W-1:0]     coef_rdata;
  logic [TAP_COUNT-1:0]  dl_vld_r, coef_vld_r;
  logic                  dv_r, cv_r;
  logic signed [COEF_W-1:0] coef_g;
  logic signed [SMP_W-1:0]  x_i, x_q;
  logic [ACC_W-1:0]      acc_i, acc_q;
  logic                  last_r;
  logic                  out_valid_r;
  logic [SMP_W-1:0]      out_i_r, out_q_r;
  logic                  out_last_r;

  assign in_acc     = in_valid && !in_stall;
  assign smp_acc    = in_acc && (in_kind == KIND_SAMPLE);
  assign coef_wr    = in_acc && (in_kind == KIND_COEF) && (int'(in_tap_index) < TAP_COUNT);
  assign coef_waddr = TAP_W'(in_tap_index);
  assign out_free   = !out_valid_r || !out_stall;

  cfir_seq #(.TAP_COUNT(TAP_COUNT)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_acc   (smp_acc),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .wpos      (wpos),
    .rd_addr   (rd_addr),
    .coef_addr (coef_addr),
    .ctrl      (ctrl)
  );

  // q in the upper half, i in the lower half
  cfir_ram #(.WIDTH(2*SMP_W), .DEPTH(TAP_COUNT)) u_dl_ram (
    .clk     (clk),
    .wr_en   (smp_acc),
    .wr_addr (wpos),
    .wr_data ({in_sample_q, in_sample_i}),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (dl_rdata)
  );

  cfir_ram #(.WIDTH(COEF_W), .DEPTH(TAP_COUNT)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (coef_waddr),
    .wr_data (in_coef_value),
    .rd_en   (ctrl.rd_en),
    .rd_addr (coef_addr),
    .rd_data (coef_rdata)
  );

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r   <= '0;
      coef_vld_r <= '0;
    end else begin
      if (smp_acc) dl_vld_r[wpos] <= 1'b1;
      if (coef_wr) coef_vld_r[coef_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      dv_r <= dl_vld_r[rd_addr];
      cv_r <= coef_vld_r[coef_addr];
    end
    if (smp_acc) begin
      last_r <= in_last_in_block;
    end
  end

  assign coef_g = cv_r ? coef_rdata : '0;
  assign x_i    = dv_r ? dl_rdata[SMP_W-1:0] : '0;
  assign x_q    = dv_r ? dl_rdata[2*SMP_W-1:SMP_W] : '0;

  cfir_mac_lane u_lane_i (
    .clk  (clk),
    .ctrl (ctrl),
    .coef (coef_g),
    .smp  (x_i),
    .acc  (acc_i)
  );

  cfir_mac_lane u_lane_q (
    .clk  (clk),
    .ctrl (ctrl),
    .coef (coef_g),
    .smp  (x_q),
    .acc  (acc_q)
  );

  // merge: top halves of both rails into the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_i_r    <= acc_i[ACC_W-1:ACC_W-SMP_W];
      out_q_r    <= acc_q[ACC_W-1:ACC_W-SMP_W];
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_i             = out_i_r;
  assign out_q             = out_q_r;
  assign out_last_of_block = out_last_r;

endmodule
